// ----- rtl/dfir_pkg.sv -----
package dfir_pkg;

    localparam int TAPS        = 121;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;

    localparam int ADDR_W = $clog2(TAPS);
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int SHIFT  = COEF_BITS - 1;
    localparam int RND_W  = ACC_W - SHIFT;

    localparam int OP_W      = 2;
    localparam int DEC_W     = 8;
    localparam int PHASE_W   = 8;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_COEF  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [DEC_W-1:0]  DEC_RESET = 8'd15;
    localparam logic [ADDR_W-1:0] LAST_TAP  = ADDR_W'(TAPS - 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

endpackage

// ----- rtl/decimating_fir_filter.sv -----
// Decimating FIR filter, 121 taps, Q1.15 samples and Q1.17 coefficients.
// Input channel (in_valid/in_ready) carries one transaction per item:
//   push sample, write coefficient, or clear history and phase.
// Output channel (out_valid/out_ready) carries one filtered sample for every
//   decimation-th pushed sample, rounded half up and saturated to 16 bits.
// cfg_write_en/cfg_write_data load the decimation factor (0 acts as 1);
//   write it only while the block is idle.
// Coefficient writes, clears and non-final pushes complete on acceptance and leave in_ready high.
// A push that completes a phase runs one multiply-accumulate unit over all
//   121 taps, one tap per cycle, reading history and coefficient memories:
//   the products pass through the read, product and accumulator registers, and
//   the saturated result is loaded once the output register is free; in_ready is
//   low during that walk, so the next transaction waits until that load.
// The output register decouples the sides: new items are accepted while a
//   result waits. If the receiver stalls and a second result is ready, the
//   block holds it and keeps in_ready low until the output register frees up.
// Reset clears history and coefficients (per-entry valid bits, no sweep),
//   the write position and phase, and sets decimation to 15.
module decimating_fir_filter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [dfir_pkg::OP_W-1:0]             operation,
    input  logic signed [dfir_pkg::SAMPLE_BITS-1:0] sample_value,
    input  logic [dfir_pkg::ADDR_W-1:0]           coef_index,
    input  logic signed [dfir_pkg::COEF_BITS-1:0] coef_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [dfir_pkg::SAMPLE_BITS-1:0] output_sample,
    input  logic                                  cfg_write_en,
    input  logic [dfir_pkg::DEC_W-1:0]            cfg_write_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    localparam int TAPS = dfir_pkg::TAPS;
    localparam int AW   = dfir_pkg::ADDR_W;
    localparam int SB   = dfir_pkg::SAMPLE_BITS;

    // Memories: history ring and coefficient store
    dfir_pkg::sample_t hist_mem [TAPS];
    dfir_pkg::coef_t   coef_mem [TAPS];

    logic [TAPS-1:0] hist_valid_reg;
    logic [TAPS-1:0] coef_valid_reg;

    logic [1:0]                   state_reg;
    logic [dfir_pkg::DEC_W-1:0]   decimation_reg;
    logic [AW-1:0]                wp_reg;
    logic [dfir_pkg::PHASE_W-1:0] phase_reg;
    logic [AW-1:0]                k_reg;
    logic [AW-1:0]                pos_reg;

    // MAC pipeline: read stage, product stage, accumulator
    dfir_pkg::sample_t hist_rd_reg;
    dfir_pkg::coef_t   coef_rd_reg;
    logic              hist_ok_reg;
    logic              coef_ok_reg;
    logic              rd_vld_reg;
    logic              rd_last_reg;
    dfir_pkg::prod_t   prod_reg;
    logic              prod_vld_reg;
    logic              prod_last_reg;
    dfir_pkg::acc_t    acc_reg;

    logic                                 out_valid_reg;
    logic signed [SB-1:0]                 output_sample_reg;

    logic                          accept;
    logic                          is_push;
    logic                          is_coef;
    logic                          is_clear;
    logic                          issuing;
    logic [dfir_pkg::PHASE_W-1:0]  phase_inc;
    logic [dfir_pkg::DEC_W-1:0]    dec_eff;
    logic                          fire;
    logic [AW-1:0]                 wp_next;
    logic [AW-1:0]                 pos_next;
    dfir_pkg::sample_t             hist_eff;
    dfir_pkg::coef_t               coef_eff;
    dfir_pkg::acc_t                prod_ext;
    dfir_pkg::acc_t                rounded;
    logic signed [dfir_pkg::RND_W-1:0] shifted;
    logic signed [SB-1:0]          sat_value;
    logic                          out_free;

    assign in_ready      = (state_reg == S_IDLE);
    assign accept        = in_valid && in_ready;
    assign is_push       = accept && (operation == dfir_pkg::OP_PUSH);
    assign is_coef       = accept && (operation == dfir_pkg::OP_COEF)
                           && (coef_index <= dfir_pkg::LAST_TAP);
    assign is_clear      = accept && (operation == dfir_pkg::OP_CLEAR);
    assign issuing       = (state_reg == S_ISSUE);
    assign out_valid     = out_valid_reg;
    assign output_sample = output_sample_reg;
    assign out_free      = !out_valid_reg || out_ready;

    // Phase: an 8-bit wrap to zero also counts as reaching the factor
    always_comb
    begin
        phase_inc = phase_reg + 1'b1;
        dec_eff   = (decimation_reg == '0) ? dfir_pkg::DEC_W'(1) : decimation_reg;
        fire      = (phase_inc == '0) || (phase_inc >= dec_eff);
        wp_next   = (wp_reg == dfir_pkg::LAST_TAP) ? '0 : wp_reg + 1'b1;
        pos_next  = (pos_reg == '0) ? dfir_pkg::LAST_TAP : pos_reg - 1'b1;
    end

    // Entries never written since reset (or clear, for history) read as zero
    always_comb
    begin
        hist_eff = hist_ok_reg ? hist_rd_reg : '0;
        coef_eff = coef_ok_reg ? coef_rd_reg : '0;
        prod_ext = {{(dfir_pkg::ACC_W - dfir_pkg::PROD_W){prod_reg[dfir_pkg::PROD_W-1]}},
                    prod_reg};
    end

    // Round half up, floor shift, saturate to the sample range
    always_comb
    begin
        rounded = acc_reg + dfir_pkg::ACC_W'(1 << (dfir_pkg::SHIFT - 1));
        shifted = rounded[dfir_pkg::ACC_W-1:dfir_pkg::SHIFT];
        if ((shifted[dfir_pkg::RND_W-1:SB-1] == '0)
            || (shifted[dfir_pkg::RND_W-1:SB-1] == '1))
        begin
            sat_value = shifted[SB-1:0];
        end
        else if (shifted[dfir_pkg::RND_W-1])
        begin
            sat_value = {1'b1, {(SB-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(SB-1){1'b1}}};
        end
    end

    // History memory: write on push, read one tap per cycle
    always_ff @(posedge clk)
    begin
        if (is_push)
        begin
            hist_mem[wp_reg] <= sample_value;
        end
        hist_rd_reg <= hist_mem[pos_reg];
    end

    // Coefficient memory
    always_ff @(posedge clk)
    begin
        if (is_coef)
        begin
            coef_mem[coef_index] <= coef_value;
        end
        coef_rd_reg <= coef_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= hist_eff * coef_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            decimation_reg    <= dfir_pkg::DEC_RESET;
            wp_reg            <= '0;
            phase_reg         <= '0;
            k_reg             <= '0;
            pos_reg           <= '0;
            hist_valid_reg    <= '0;
            coef_valid_reg    <= '0;
            hist_ok_reg       <= 1'b0;
            coef_ok_reg       <= 1'b0;
            rd_vld_reg        <= 1'b0;
            rd_last_reg       <= 1'b0;
            prod_vld_reg      <= 1'b0;
            prod_last_reg     <= 1'b0;
            acc_reg           <= '0;
            out_valid_reg     <= 1'b0;
            output_sample_reg <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                decimation_reg <= cfg_write_data;
            end

            hist_ok_reg   <= hist_valid_reg[pos_reg];
            coef_ok_reg   <= coef_valid_reg[k_reg];
            rd_vld_reg    <= issuing;
            rd_last_reg   <= issuing && (k_reg == dfir_pkg::LAST_TAP);
            prod_vld_reg  <= rd_vld_reg;
            prod_last_reg <= rd_last_reg;

            if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + prod_ext;
            end

            // Drop the sent result unless a held one refills the register
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (is_coef)
                    begin
                        coef_valid_reg[coef_index] <= 1'b1;
                    end
                    if (is_clear)
                    begin
                        hist_valid_reg <= '0;
                        wp_reg         <= '0;
                        phase_reg      <= '0;
                    end
                    if (is_push)
                    begin
                        hist_valid_reg[wp_reg] <= 1'b1;
                        wp_reg                 <= wp_next;
                        if (fire)
                        begin
                            // Start the walk at the newest sample
                            phase_reg <= '0;
                            k_reg     <= '0;
                            pos_reg   <= wp_reg;
                            acc_reg   <= '0;
                            state_reg <= S_ISSUE;
                        end
                        else
                        begin
                            phase_reg <= phase_inc;
                        end
                    end
                end
                S_ISSUE:
                begin
                    pos_reg <= pos_next;
                    if (k_reg == dfir_pkg::LAST_TAP)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_WAIT:
                begin
                    if (prod_vld_reg && prod_last_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // Hold the result until the output register frees up
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        output_sample_reg <= sat_value;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
